/* hdl/ohm_pkg.sv */
// ----------------------------------------------------------------------------
// ohm_pkg: shared types and constants of the ordered hash map engine
// sizes, op and status codes, controller states, control words between units
// ----------------------------------------------------------------------------
package ohm_pkg;

	localparam int ENTRIES     = 64;
	localparam int SLOTS       = 128;
	localparam int PROBE_LIMIT = SLOTS + 16;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int STEP_W = $clog2(PROBE_LIMIT);

	localparam int KEY_W     = 64;
	localparam int HASH_W    = 32;
	localparam int VAL_W     = 64;
	localparam int PERTURB_W = 64;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int SHIFT     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_DEFAULT  = 3'd3,
		ST_KEY_ERR  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEFAULT_ENABLE = 1'b0,
		CFG_DEFAULT_VALUE  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_REDUCE,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              update;
		logic              append;
		logic [KEY_W-1:0]  req_key;
		logic [HASH_W-1:0] req_hash;
		logic [VAL_W-1:0]  wr_value;
		logic              wr_given;
	} cell_ctl_t;

	typedef struct packed {
		logic              start;
		logic              claim;
		logic              clear;
		logic [HASH_W-1:0] hash;
	} probe_ctl_t;

	typedef struct packed {
		logic              done;
		logic              empty;
		logic [SLOT_W-1:0] slot;
	} probe_sts_t;

endpackage

/* hdl/ordered_hash_map_engine_top.sv */
// ----------------------------------------------------------------------------
// ordered_hash_map_engine_top: insertion-ordered hash map engine
// row of entry cells with parallel key match, open-addressing slot prober,
// controller and output register
// ----------------------------------------------------------------------------
//  channel | signals                                         | moves
//  in      | in_valid, in_stall, op .. value_given           | one request word
//  out     | out_valid, out_stall, status .. entry_count     | one result word
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | one register write
//
// result word is registered after the match, reduce and decide steps; the next
// word can be accepted as soon as the result word is valid
// a new-key insert with room left holds in decide until the prober, one slot
// per cycle (at most SLOTS+16 slots), reaches a free slot or the step limit
// one word is in flight at a time; a held result does not block the next accept,
// it only delays that word's decide step while out_stall is high
// reset empties the map at once and sets both registers to zero
// ----------------------------------------------------------------------------
module ordered_hash_map_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ohm_pkg::OP_W-1:0]         op,
	input  logic signed [ohm_pkg::HASH_W-1:0] key_hash,
	input  logic [ohm_pkg::KEY_W-1:0]        key_token,
	input  logic [ohm_pkg::VAL_W-1:0]        value_in,
	input  logic                             value_given,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ohm_pkg::STATUS_W-1:0]     status,
	output logic [ohm_pkg::IDX_W-1:0]        entry_index,
	output logic [ohm_pkg::VAL_W-1:0]        result_value,
	output logic [ohm_pkg::CNT_W-1:0]        entry_count,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ohm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ohm_pkg::VAL_W-1:0]        cfg_data
);

	ohm_pkg::state_t                 state_q, state_d;
	logic                            accept;
	logic                            commit;
	logic                            go;

	logic [ohm_pkg::OP_W-1:0]        req_op_q;
	logic [ohm_pkg::HASH_W-1:0]      req_hash_q;
	logic [ohm_pkg::KEY_W-1:0]       req_key_q;
	logic [ohm_pkg::VAL_W-1:0]       req_val_q;
	logic                            req_given_q;

	logic                            dflt_en_q;
	logic [ohm_pkg::VAL_W-1:0]       dflt_val_q;
	logic [ohm_pkg::CNT_W-1:0]       count_q;

	logic [ohm_pkg::ENTRIES:0]       live_chain;
	logic [ohm_pkg::ENTRIES-1:0]     hit;
	logic [ohm_pkg::VAL_W-1:0]       shown [ohm_pkg::ENTRIES];
	ohm_pkg::cell_ctl_t              cell_ctl;

	logic                            red_hit;
	logic [ohm_pkg::IDX_W-1:0]       red_idx;
	logic [ohm_pkg::VAL_W-1:0]       red_val;
	logic                            red_hit_q;
	logic [ohm_pkg::IDX_W-1:0]       red_idx_q;
	logic [ohm_pkg::VAL_W-1:0]       red_val_q;

	ohm_pkg::probe_ctl_t             probe_ctl;
	ohm_pkg::probe_sts_t             probe_sts;

	logic                            is_clr;
	logic                            is_ins;
	logic                            has_room;
	logic                            need_probe;
	logic                            do_update;
	logic                            do_append;
	ohm_pkg::status_t                res_status;
	logic [ohm_pkg::IDX_W-1:0]       res_idx;
	logic [ohm_pkg::VAL_W-1:0]       res_val;
	logic [ohm_pkg::CNT_W-1:0]       res_cnt;
	logic [ohm_pkg::VAL_W-1:0]       ins_shown;

	logic                            out_valid_q;
	logic [ohm_pkg::STATUS_W-1:0]    status_q;
	logic [ohm_pkg::IDX_W-1:0]       index_q;
	logic [ohm_pkg::VAL_W-1:0]       value_q;
	logic [ohm_pkg::CNT_W-1:0]       cnt_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_en_q  <= 1'b0;
			dflt_val_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ohm_pkg::CFG_DEFAULT_ENABLE: dflt_en_q  <= cfg_data[0];
				ohm_pkg::CFG_DEFAULT_VALUE:  dflt_val_q <= cfg_data;
			endcase
		end
	end

	// request capture
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q    <= op;
			req_hash_q  <= key_hash;
			req_key_q   <= key_token;
			req_val_q   <= value_in;
			req_given_q <= value_given;
		end
	end

	// entry row
	assign live_chain[0] = 1'b1;

	for (genvar i = 0; i < ohm_pkg::ENTRIES; i++) begin : g_cell
		ohm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.live_prev (live_chain[i]),
			.live      (live_chain[i+1]),
			.hit       (hit[i]),
			.shown     (shown[i])
		);
	end

	always_comb begin
		red_hit = 1'b0;
		red_idx = '0;
		red_val = '0;
		for (int i = 0; i < ohm_pkg::ENTRIES; i++) begin
			red_hit = red_hit | hit[i];
			red_idx = red_idx | (hit[i] ? ohm_pkg::IDX_W'(i) : '0);
			red_val = red_val | (hit[i] ? shown[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		red_hit_q <= red_hit;
		red_idx_q <= red_idx;
		red_val_q <= red_val;
	end

	// slot prober
	ohm_prober u_prober (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (probe_ctl),
		.sts    (probe_sts)
	);

	// decision
	always_comb begin
		is_clr     = (req_op_q == ohm_pkg::OP_CLEAR);
		is_ins     = (req_op_q == ohm_pkg::OP_INSERT);
		has_room   = (count_q < ohm_pkg::CNT_W'(ohm_pkg::ENTRIES));
		need_probe = is_ins && !red_hit_q && has_room;
		ins_shown  = req_given_q ? req_val_q : req_key_q;
		do_update  = 1'b0;
		do_append  = 1'b0;
		res_status = ohm_pkg::ST_INSERTED;
		res_idx    = '0;
		res_val    = '0;
		res_cnt    = count_q;
		if (is_clr) begin
			res_cnt = '0;
		end else if (is_ins) begin
			if (red_hit_q) begin
				do_update  = 1'b1;
				res_status = ohm_pkg::ST_UPDATED;
				res_idx    = red_idx_q;
				res_val    = ins_shown;
			end else if (!has_room || !probe_sts.empty) begin
				res_status = ohm_pkg::ST_FULL;
			end else begin
				do_append  = 1'b1;
				res_status = ohm_pkg::ST_INSERTED;
				res_idx    = count_q[ohm_pkg::IDX_W-1:0];
				res_val    = ins_shown;
				res_cnt    = count_q + ohm_pkg::CNT_W'(1);
			end
		end else if (red_hit_q) begin
			res_status = ohm_pkg::ST_FOUND;
			res_idx    = red_idx_q;
			res_val    = red_val_q;
		end else if (dflt_en_q) begin
			res_status = ohm_pkg::ST_DEFAULT;
			res_val    = dflt_val_q;
		end else begin
			res_status = ohm_pkg::ST_KEY_ERR;
		end
	end

	assign go = (!need_probe || probe_sts.done) && (!out_valid_q || !out_stall);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ohm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ohm_pkg::S_IDLE:   if (accept) state_d = ohm_pkg::S_MATCH;
			ohm_pkg::S_MATCH:  state_d = ohm_pkg::S_REDUCE;
			ohm_pkg::S_REDUCE: state_d = ohm_pkg::S_DECIDE;
			ohm_pkg::S_DECIDE: if (go) state_d = ohm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ohm_pkg::S_IDLE);
		commit   = (state_q == ohm_pkg::S_DECIDE) && go;

		cell_ctl.clear    = commit && is_clr;
		cell_ctl.update   = commit && do_update;
		cell_ctl.append   = commit && do_append;
		cell_ctl.req_key  = req_key_q;
		cell_ctl.req_hash = req_hash_q;
		cell_ctl.wr_value = req_val_q;
		cell_ctl.wr_given = req_given_q;

		probe_ctl.start = accept && (op != ohm_pkg::OP_CLEAR);
		probe_ctl.claim = commit && do_append;
		probe_ctl.clear = commit && is_clr;
		probe_ctl.hash  = key_hash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= res_cnt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= res_status;
			index_q  <= res_idx;
			value_q  <= res_val;
			cnt_q    <= res_cnt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_index  = index_q;
	assign result_value = value_q;
	assign entry_count  = cnt_q;

	// checks
	a_live_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_chain[ohm_pkg::ENTRIES:1]) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one cell matches the request");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ohm_pkg::S_DECIDE))
		else $error("result word appeared outside the decide step");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_clr) |=> (count_q == '0) && (live_chain[1] == 1'b0))
		else $error("clear left entries behind");

endmodule

/* hdl/ohm_cell.sv */
// ----------------------------------------------------------------------------
// ohm_cell: one entry of the insertion-ordered entry row
// holds key, hash and optional value; compares against the request; the
// occupancy bit is taken from the left neighbor so appends land in order
// ----------------------------------------------------------------------------
module ohm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ohm_pkg::cell_ctl_t          ctl,
	input  logic                        live_prev,
	output logic                        live,
	output logic                        hit,
	output logic [ohm_pkg::VAL_W-1:0]   shown
);

	logic                        live_q;
	logic                        hit_q;
	logic [ohm_pkg::KEY_W-1:0]   key_q;
	logic [ohm_pkg::HASH_W-1:0]  hash_q;
	logic [ohm_pkg::VAL_W-1:0]   value_q;
	logic                        given_q;
	logic                        take;

	assign take = ctl.append && live_prev && !live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			hit_q <= live_q && (key_q == ctl.req_key) && (hash_q == ctl.req_hash);
			if (ctl.clear) begin
				live_q <= 1'b0;
			end else if (take) begin
				live_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= ctl.req_key;
			hash_q  <= ctl.req_hash;
			value_q <= ctl.wr_given ? ctl.wr_value : '0;
			given_q <= ctl.wr_given;
		end else if (ctl.update && hit_q) begin
			value_q <= ctl.wr_given ? ctl.wr_value : '0;
			given_q <= ctl.wr_given;
		end
	end

	assign live  = live_q;
	assign hit   = hit_q;
	assign shown = given_q ? value_q : key_q;

endmodule

/* hdl/ohm_prober.sv */
// ----------------------------------------------------------------------------
// ohm_prober: slot occupancy and open-addressing probe walker
// one slot checked per cycle until an empty slot or the step limit
// ----------------------------------------------------------------------------
module ohm_prober (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ohm_pkg::probe_ctl_t  ctl,
	output ohm_pkg::probe_sts_t  sts
);

	logic [ohm_pkg::SLOTS-1:0]      used_q;
	logic [ohm_pkg::SLOT_W-1:0]     slot_q;
	logic [ohm_pkg::PERTURB_W-1:0]  perturb_q;
	logic [ohm_pkg::STEP_W-1:0]     steps_q;
	logic                           busy_q;
	logic                           empty_q;
	logic [ohm_pkg::PERTURB_W-1:0]  perturb_next;
	logic [ohm_pkg::SLOT_W-1:0]     slot_x5;
	logic [ohm_pkg::SLOT_W-1:0]     slot_next;

	assign perturb_next = perturb_q >> ohm_pkg::SHIFT;
	assign slot_x5      = (slot_q << 2) + slot_q;
	assign slot_next    = slot_x5 + perturb_next[ohm_pkg::SLOT_W-1:0] + ohm_pkg::SLOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			busy_q  <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				used_q <= '0;
			end else if (ctl.claim) begin
				used_q[slot_q] <= 1'b1;
			end
			if (ctl.start) begin
				busy_q  <= 1'b1;
				empty_q <= 1'b0;
			end else if (busy_q) begin
				if (!used_q[slot_q]) begin
					busy_q  <= 1'b0;
					empty_q <= 1'b1;
				end else if (steps_q == ohm_pkg::STEP_W'(ohm_pkg::PROBE_LIMIT - 1)) begin
					busy_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			slot_q    <= ctl.hash[ohm_pkg::SLOT_W-1:0];
			perturb_q <= {{(ohm_pkg::PERTURB_W - ohm_pkg::HASH_W){ctl.hash[ohm_pkg::HASH_W-1]}},
				ctl.hash};
			steps_q   <= '0;
		end else if (busy_q && used_q[slot_q]) begin
			slot_q    <= slot_next;
			perturb_q <= perturb_next;
			steps_q   <= steps_q + ohm_pkg::STEP_W'(1);
		end
	end

	assign sts.done  = !busy_q;
	assign sts.empty = empty_q;
	assign sts.slot  = slot_q;

endmodule
